// ----- hdl/rfmc_pkg.sv -----
package rfmc_pkg;

	// Fixed field widths of the command and result words.
	localparam int WORD_WIDTH    = 32;
	localparam int CMD_W         = 3;
	localparam int STATUS_W      = 2;
	localparam int COUNT_W       = 9;
	localparam int FILL_W        = 9;
	localparam int CFG_W         = 4;

	localparam int DEF_MAX_DEPTH = 256;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_PUSH  = CMD_W'(0);
	localparam logic [CMD_W-1:0] CMD_POP   = CMD_W'(1);
	localparam logic [CMD_W-1:0] CMD_PEEK  = CMD_W'(2);
	localparam logic [CMD_W-1:0] CMD_COUNT = CMD_W'(3);
	localparam logic [CMD_W-1:0] CMD_FLUSH = CMD_W'(4);

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK    = STATUS_W'(0);
	localparam logic [STATUS_W-1:0] ST_FULL  = STATUS_W'(1);
	localparam logic [STATUS_W-1:0] ST_EMPTY = STATUS_W'(2);

	// Control of the compare and count unit.
	typedef struct packed {
		logic clear;
		logic sample;
	} match_ctl_t;

endpackage

// ----- hdl/ring_fifo_with_match_count_core.sv -----
// Ring FIFO with a match counter.
// Commands enter on the in channel (in_valid / in_ready, fields command and
// data_in); each command yields exactly one result word on the out channel
// (out_valid / out_ready, fields status, data_out, match_count, fill_level).
// The capacity register (log2 of the entries in use) is written over the cfg
// channel; a write also clears both positions. The user must write it only
// while no command is in flight; the block itself does not enforce this.
// cfg_ready is always high. Push, flush, unknown codes, and pop, peek or
// count on an empty FIFO finish in the cycle of acceptance and their result
// is registered; they run at one per cycle while in_ready stays high. Pop
// and peek of a stored word also pass the registered read port of the store.
// Count walks the stored words one per cycle through a single comparator.
// in_ready is low while a read or a scan is in progress, and while a finished
// result waits in the hold register behind a full output register.
// The output register holds its word while out_ready is low; one more command
// may be accepted meanwhile, and its result is parked until the output frees.
// Reset clears both positions, sets the capacity to its largest value and
// empties the output; the store contents are not cleared.
module ring_fifo_with_match_count_core #(
	parameter int MAX_DEPTH = rfmc_pkg::DEF_MAX_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rfmc_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [rfmc_pkg::CMD_W-1:0]       command,
	input  logic [rfmc_pkg::WORD_WIDTH-1:0]  data_in,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [rfmc_pkg::STATUS_W-1:0]    status,
	output logic [rfmc_pkg::WORD_WIDTH-1:0]  data_out,
	output logic [rfmc_pkg::COUNT_W-1:0]     match_count,
	output logic [rfmc_pkg::FILL_W-1:0]      fill_level
);
	import rfmc_pkg::*;

	// Largest power of two not above MAX_DEPTH, its log2, and the widths that follow.
	localparam int LgMax  = ((1 << $clog2(MAX_DEPTH)) == MAX_DEPTH) ?
		$clog2(MAX_DEPTH) : $clog2(MAX_DEPTH) - 1;
	localparam int CapMax = 1 << LgMax;
	localparam int PW     = LgMax + 1;
	localparam int AW     = (LgMax > 0) ? LgMax : 1;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_SCAN = 4'b0100,
		S_HOLD = 4'b1000
	} state_t;

	state_t state_q, state_d;

	logic [CFG_W-1:0] cap_q;
	logic [CFG_W:0]   lg_eff;
	logic [PW-1:0]    cap_size;
	logic [AW-1:0]    addr_mask;

	logic [PW-1:0] wp_q, rp_q, wp_d, rp_d;
	logic [PW-1:0] fill_now;

	logic cfg_fire, in_accept, out_free, out_load;

	// Scan sequencer.
	logic [PW-1:0]         n_q, idx_q;
	logic [WORD_WIDTH-1:0] probe_q;
	logic                  scan_start, scan_issue, scan_vld_s1;
	logic [PW-1:0]         match_cnt;
	match_ctl_t            mctl;

	// Store ports.
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr, ram_raddr;
	logic [WORD_WIDTH-1:0] ram_rdata;

	// Result of the command finishing in this cycle.
	logic                  res_vld;
	logic [STATUS_W-1:0]   res_status;
	logic [WORD_WIDTH-1:0] res_data;
	logic [PW-1:0]         res_match, res_fill;

	// Parked result and the one selected for the output register.
	logic [STATUS_W-1:0]   hold_status_q, sel_status;
	logic [WORD_WIDTH-1:0] hold_data_q, sel_data;
	logic [PW-1:0]         hold_match_q, hold_fill_q, sel_match, sel_fill;
	logic [PW+COUNT_W-1:0] match_ext;
	logic [PW+FILL_W-1:0]  fill_ext;

	logic                  out_valid_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic [WORD_WIDTH-1:0] out_data_q;
	logic [COUNT_W-1:0]    out_match_q;
	logic [FILL_W-1:0]     out_fill_q;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign in_accept = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// A capacity above what the store holds saturates to the store size.
	always_comb begin
		lg_eff = ({1'b0, cap_q} > (CFG_W + 1)'(LgMax)) ? (CFG_W + 1)'(LgMax) : {1'b0, cap_q};
	end
	assign cap_size  = PW'(1) << lg_eff;
	assign addr_mask = AW'(cap_size - PW'(1));
	assign fill_now  = wp_q - rp_q;

	assign ram_waddr  = AW'(wp_q) & addr_mask;
	assign ram_raddr  = (state_q == S_SCAN) ? (AW'(rp_q + idx_q) & addr_mask) :
		(AW'(rp_q) & addr_mask);
	assign scan_issue = (state_q == S_SCAN) && (idx_q != n_q);

	always_comb begin
		state_d    = state_q;
		wp_d       = wp_q;
		rp_d       = rp_q;
		res_vld    = 1'b0;
		res_status = ST_OK;
		res_data   = '0;
		res_match  = '0;
		ram_we     = 1'b0;
		scan_start = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					unique case (command) inside
						CMD_PUSH: begin
							res_vld = 1'b1;
							if (fill_now >= cap_size) begin
								res_status = ST_FULL;
							end else begin
								ram_we = 1'b1;
								wp_d   = wp_q + PW'(1);
							end
						end
						CMD_POP, CMD_PEEK: begin
							if (fill_now == '0) begin
								res_vld    = 1'b1;
								res_status = ST_EMPTY;
							end else begin
								state_d = S_READ;
								if (command == CMD_POP) begin
									rp_d = rp_q + PW'(1);
								end
							end
						end
						CMD_COUNT: begin
							if (fill_now == '0) begin
								res_vld = 1'b1;
							end else begin
								state_d    = S_SCAN;
								scan_start = 1'b1;
							end
						end
						CMD_FLUSH: begin
							res_vld = 1'b1;
							wp_d    = '0;
							rp_d    = '0;
						end
						default: begin
							res_vld = 1'b1;
						end
					endcase
				end
			end
			S_READ: begin
				res_vld  = 1'b1;
				res_data = ram_rdata;
			end
			S_SCAN: begin
				if ((idx_q == n_q) && !scan_vld_s1) begin
					res_vld   = 1'b1;
					res_match = match_cnt;
				end
			end
			S_HOLD: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (res_vld) begin
			state_d = out_free ? S_IDLE : S_HOLD;
		end
		if (cfg_fire) begin
			wp_d = '0;
			rp_d = '0;
		end
	end

	assign res_fill = wp_d - rp_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cap_q       <= CFG_RESET;
			wp_q        <= '0;
			rp_q        <= '0;
			n_q         <= '0;
			idx_q       <= '0;
			scan_vld_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			wp_q        <= wp_d;
			rp_q        <= rp_d;
			scan_vld_s1 <= scan_issue;
			if (cfg_fire) begin
				cap_q <= cfg_data;
			end
			if (scan_start) begin
				n_q   <= fill_now;
				idx_q <= '0;
			end else if (scan_issue) begin
				idx_q <= idx_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_start) begin
			probe_q <= data_in;
		end
	end

	assign mctl.clear  = scan_start;
	assign mctl.sample = scan_vld_s1;

	rfmc_ram #(
		.WIDTH(WORD_WIDTH),
		.DEPTH(CapMax)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(data_in),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	rfmc_match #(
		.CNT_W(PW)
	) u_match (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (mctl),
		.probe (probe_q),
		.rdata (ram_rdata),
		.count (match_cnt)
	);

	// A result finished behind a stalled output is parked here.
	always_ff @(posedge clk) begin
		if (res_vld && !out_free) begin
			hold_status_q <= res_status;
			hold_data_q   <= res_data;
			hold_match_q  <= res_match;
			hold_fill_q   <= res_fill;
		end
	end

	assign sel_status = (state_q == S_HOLD) ? hold_status_q : res_status;
	assign sel_data   = (state_q == S_HOLD) ? hold_data_q : res_data;
	assign sel_match  = (state_q == S_HOLD) ? hold_match_q : res_match;
	assign sel_fill   = (state_q == S_HOLD) ? hold_fill_q : res_fill;
	assign match_ext  = {{COUNT_W{1'b0}}, sel_match};
	assign fill_ext   = {{FILL_W{1'b0}}, sel_fill};
	assign out_load   = out_free && (res_vld || (state_q == S_HOLD));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= sel_status;
			out_data_q   <= sel_data;
			out_match_q  <= match_ext[COUNT_W-1:0];
			out_fill_q   <= fill_ext[FILL_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign data_out    = out_data_q;
	assign match_count = out_match_q;
	assign fill_level  = out_fill_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(wp_q - rp_q) <= PW'(CapMax))
		else $error("fill level exceeds the store size");

	a_read_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |=> (state_q == S_IDLE || state_q == S_HOLD))
		else $error("read state lasted more than one cycle");

	a_scan_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (idx_q <= n_q && match_cnt <= idx_q))
		else $error("scan index or match count out of range");

	a_hold_needs_full_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HOLD) |-> out_valid_q)
		else $error("result parked while the output register is empty");

	a_scan_positions_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && !cfg_fire) |=> ($stable(wp_q) && $stable(rp_q)))
		else $error("positions moved during a scan");
`endif

endmodule

// ----- hdl/rfmc_ram.sv -----
module rfmc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/rfmc_match.sv -----
module rfmc_match #(
	parameter int CNT_W = 9
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rfmc_pkg::match_ctl_t           ctl,
	input  logic [rfmc_pkg::WORD_WIDTH-1:0] probe,
	input  logic [rfmc_pkg::WORD_WIDTH-1:0] rdata,
	output logic [CNT_W-1:0]               count
);
	import rfmc_pkg::*;

	logic [CNT_W-1:0] count_q;

	// One comparator, fed one stored word per cycle during a scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.clear) begin
			count_q <= '0;
		end else if (ctl.sample && (rdata == probe)) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	assign count = count_q;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

import rfmc_pkg::*;

// One result word as the out channel presents it.
typedef struct packed {
	logic [STATUS_W-1:0]   status;
	logic [WORD_WIDTH-1:0] word;
	logic [COUNT_W-1:0]    hits;
	logic [FILL_W-1:0]     level;
} fifo_result_t;

// Shadow copy of the ring store and its positions, plus the queue of result
// words that the block still owes.
class fifo_scoreboard;
	logic [WORD_WIDTH-1:0] words [DEF_MAX_DEPTH];
	logic [FILL_W-1:0]     wr_pos;
	logic [FILL_W-1:0]     rd_pos;
	logic [CFG_W-1:0]      cap_log2;
	fifo_result_t          owed_q[$];
	int                    errors;

	function new();
		foreach (words[i])
			words[i] = '0;
		wr_pos   = '0;
		rd_pos   = '0;
		cap_log2 = CFG_RESET;
		errors   = 0;
	endfunction

	// Sizes past the store depth saturate to the full store.
	function int capacity();
		int cap;
		cap = 1 << cap_log2;
		if (cap > DEF_MAX_DEPTH)
			cap = DEF_MAX_DEPTH;
		return cap;
	endfunction

	function int pending();
		return owed_q.size();
	endfunction

	function void set_capacity(logic [CFG_W-1:0] value);
		cap_log2 = value;
		wr_pos   = '0;
		rd_pos   = '0;
	endfunction

	function void note_command(logic [CMD_W-1:0] cmd, logic [WORD_WIDTH-1:0] word);
		fifo_result_t     r;
		int               cap;
		logic [FILL_W-1:0] mask;
		logic [FILL_W-1:0] lvl;
		cap  = capacity();
		mask = FILL_W'(cap - 1);
		lvl  = wr_pos - rd_pos;
		r    = '0;
		case (cmd)
			CMD_PUSH: begin
				if (lvl >= cap) begin
					r.status = ST_FULL;
				end else begin
					words[wr_pos & mask] = word;
					wr_pos = wr_pos + 1'b1;
				end
			end
			CMD_POP, CMD_PEEK: begin
				if (lvl == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.word = words[rd_pos & mask];
					if (cmd == CMD_POP)
						rd_pos = rd_pos + 1'b1;
				end
			end
			CMD_COUNT: begin
				for (int i = 0; i < lvl; i++)
					if (words[(rd_pos + FILL_W'(i)) & mask] == word)
						r.hits = r.hits + 1'b1;
			end
			CMD_FLUSH: begin
				wr_pos = '0;
				rd_pos = '0;
			end
			default: begin
			end
		endcase
		r.level = wr_pos - rd_pos;
		owed_q.push_back(r);
	endfunction

	function void check_result(fifo_result_t got);
		fifo_result_t want;
		if (owed_q.size() == 0) begin
			$display("%0t: result with nothing owed: status %0d data %h count %0d fill %0d",
				$time, got.status, got.word, got.hits, got.level);
			errors++;
			return;
		end
		want = owed_q.pop_front();
		if (got.status !== want.status) begin
			$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
			errors++;
		end
		if (got.word !== want.word) begin
			$display("%0t: data_out expected %h actual %h", $time, want.word, got.word);
			errors++;
		end
		if (got.hits !== want.hits) begin
			$display("%0t: match_count expected %0d actual %0d", $time, want.hits, got.hits);
			errors++;
		end
		if (got.level !== want.level) begin
			$display("%0t: fill_level expected %0d actual %0d", $time, want.level, got.level);
			errors++;
		end
	endfunction
endclass

module tb_top;

	// The three codes the block does not decode; they must leave the FIFO alone.
	localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = CMD_FLUSH + 1'b1;
	localparam logic [CMD_W-1:0] CMD_LAST_UNUSED  = '1;

	// A full-depth match scan moves no word on any channel while it walks the
	// stored words; this limit leaves a wide margin above such a scan.
	localparam int STALL_LIMIT = 3000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_W-1:0]      cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [CMD_W-1:0]      command;
	logic [WORD_WIDTH-1:0] data_in;
	logic                  out_valid;
	logic                  out_ready;
	logic [STATUS_W-1:0]   status;
	logic [WORD_WIDTH-1:0] data_out;
	logic [COUNT_W-1:0]    match_count;
	logic [FILL_W-1:0]     fill_level;

	// When set, the matching side runs back to back for a while.
	bit src_steady;
	bit sink_steady;

	// A few recurring words so that match counts are often above zero.
	logic [WORD_WIDTH-1:0] word_pool [4];

	fifo_scoreboard sb = new();

	ring_fifo_with_match_count_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.data_in     (data_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.data_out    (data_out),
		.match_count (match_count),
		.fill_level  (fill_level)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one command word after a random gap and hold it until taken. The
	// prediction is made at the accepting edge, so the owed queue follows the
	// exact order in which the block saw its commands.
	task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [WORD_WIDTH-1:0] word);
		int gap;
		if ($urandom_range(0, 39) == 0)
			src_steady = !src_steady;
		gap = src_steady ? 0 : $urandom_range(0, 11);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		data_in  <= word;
		do @(posedge clk); while (!in_ready);
		sb.note_command(cmd, word);
	endtask

	// Stop offering commands and wait until every owed result has come back.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// The capacity register is only written with the FIFO idle. Every command
	// returns a result, so an empty owed queue means nothing is in flight; the
	// short pause only lets the output side settle.
	task automatic write_capacity(input logic [CFG_W-1:0] value);
		drain();
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.set_capacity(value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [CMD_W-1:0] pick_command(input int push_pct, input bit flush_ok);
		int r;
		if ($urandom_range(0, 99) < push_pct)
			return CMD_PUSH;
		r = $urandom_range(0, 99);
		if (r < 35)
			return CMD_POP;
		if (r < 55)
			return CMD_PEEK;
		if (r < 80)
			return CMD_COUNT;
		if (r < 90)
			return flush_ok ? CMD_FLUSH : CMD_POP;
		return CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
	endfunction

	function automatic logic [WORD_WIDTH-1:0] pick_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2, 3, 4: return word_pool[$urandom_range(0, 3)];
			default: return $urandom();
		endcase
	endfunction

	// One random phase at a given capacity. Now and then the sender holds
	// off until the FIFO has answered everything, which puts the block back
	// into its idle state in the middle of a phase.
	task automatic run_phase(input logic [CFG_W-1:0] cap, input int n_items,
			input int push_pct, input bit flush_ok);
		logic [CMD_W-1:0] cmd;
		write_capacity(cap);
		repeat (n_items) begin
			if ($urandom_range(0, 59) == 0)
				drain();
			cmd = pick_command(push_pct, flush_ok);
			send_cmd(cmd, pick_word());
		end
	endtask

	// Fill the whole store with one word, so that the count reaches its top
	// value, then try one push too many.
	task automatic fill_store_uniform();
		logic [WORD_WIDTH-1:0] w;
		w = $urandom();
		write_capacity(CFG_W'($clog2(DEF_MAX_DEPTH)));
		repeat (DEF_MAX_DEPTH) send_cmd(CMD_PUSH, w);
		send_cmd(CMD_PUSH, ~w);
		send_cmd(CMD_COUNT, w);
		send_cmd(CMD_COUNT, ~w);
		send_cmd(CMD_PEEK, $urandom());
	endtask

	// Result side: a random stall before each word, with stretches of none.
	initial begin
		int stall;
		out_ready   = 1'b0;
		sink_steady = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 39) == 0)
				sink_steady = !sink_steady;
			stall = sink_steady ? 0 : $urandom_range(0, 11);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_result(fifo_result_t'({status, data_out, match_count, fill_level}));

	// Watchdog: any word moving on any channel restarts the count.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("ring_fifo_with_match_count_core test failed");
		$finish;
	end

	initial begin
		logic [WORD_WIDTH-1:0] a;
		logic [WORD_WIDTH-1:0] b;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		command    = CMD_PUSH;
		data_in    = '0;
		cfg_valid  = 1'b0;
		cfg_data   = CFG_RESET;
		src_steady = 1'b0;
		foreach (word_pool[i])
			word_pool[i] = $urandom();
		a = $urandom();
		b = $urandom();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset capacity: empty cases first, then a few
		// stored words with repeats for the counter, the undecoded codes, and
		// a flush that must leave the FIFO empty.
		send_cmd(CMD_POP, '1);
		send_cmd(CMD_PEEK, '0);
		send_cmd(CMD_COUNT, '0);
		send_cmd(CMD_PUSH, '0);
		send_cmd(CMD_PUSH, '1);
		send_cmd(CMD_PUSH, '0);
		send_cmd(CMD_PEEK, a);
		send_cmd(CMD_COUNT, '0);
		send_cmd(CMD_COUNT, '1);
		send_cmd(CMD_FIRST_UNUSED, a);
		send_cmd(CMD_FIRST_UNUSED + 1'b1, '1);
		send_cmd(CMD_LAST_UNUSED, b);
		send_cmd(CMD_POP, '0);
		send_cmd(CMD_POP, '0);
		send_cmd(CMD_FLUSH, '1);
		send_cmd(CMD_POP, '0);

		// Capacity of one entry: the second push is refused.
		write_capacity('0);
		send_cmd(CMD_PUSH, a);
		send_cmd(CMD_PUSH, b);
		send_cmd(CMD_COUNT, a);
		send_cmd(CMD_PEEK, '0);
		send_cmd(CMD_POP, '0);
		send_cmd(CMD_POP, '0);
		send_cmd(CMD_PUSH, b);

		// The largest register value saturates; the write itself must drop
		// the word left behind above, so this pop finds the FIFO empty.
		write_capacity('1);
		send_cmd(CMD_POP, '0);
		send_cmd(CMD_PUSH, a);

		fill_store_uniform();

		// Random phases over a spread of capacities. The long push-heavy
		// phase at a saturated size runs the full 256-entry store into its
		// full status with flushes held back.
		run_phase(4'd0, 60, 50, 1'b1);
		run_phase(4'd1, 100, 50, 1'b1);
		run_phase(4'd2, 150, 50, 1'b1);
		run_phase(4'd3, 200, 55, 1'b1);
		run_phase(4'd4, 150, 50, 1'b1);
		run_phase(4'd15, 340, 92, 1'b0);
		run_phase(4'd5, 150, 50, 1'b1);
		run_phase(4'd9, 80, 50, 1'b1);
		run_phase(CFG_W'($urandom_range(0, 15)), 180, 50, 1'b1);

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("ring_fifo_with_match_count_core test passed");
		else
			$display("ring_fifo_with_match_count_core test failed");
		$finish;
	end

endmodule
